@@ rtl/aes_round_transform_unit_core_macros.svh @@
// Assertion macros for the AES round transformation unit.
`ifndef AES_ROUND_TRANSFORM_UNIT_CORE_MACROS_SVH
`define AES_ROUND_TRANSFORM_UNIT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define AESRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AESRT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define AESRT_ASSERT(lbl, prop, msg)
`define AESRT_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/aesrt_pkg.sv @@
// Types, constants and byte-level transforms for the AES round transformation unit.
package aesrt_pkg;

  localparam int BYTE_W     = 8;
  localparam int TBL_AW     = 9;
  localparam int STATE_W    = 128;
  localparam int HALF_W     = 64;
  localparam int KIND_W     = 4;
  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = 128;
  localparam int LANES      = 4;
  localparam int LANE_BITS  = LANES * BYTE_W;

  localparam logic [BYTE_W-1:0] AES_POLY = 8'h1B;

  typedef logic [STATE_W-1:0] state_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_FWD_WR   = 4'd0,
    KIND_INV_WR   = 4'd1,
    KIND_SUB      = 4'd2,
    KIND_INVSUB   = 4'd3,
    KIND_SHIFT    = 4'd4,
    KIND_INVSHIFT = 4'd5,
    KIND_MIX      = 4'd6,
    KIND_INVMIX   = 4'd7,
    KIND_ADDKEY   = 4'd8
  } kind_t;

  function automatic logic [BYTE_W-1:0] xt(logic [BYTE_W-1:0] a);
    xt = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? AES_POLY : '0);
  endfunction

  // byte k sits at bits 127-8k .. 120-8k
  function automatic logic [BYTE_W-1:0] st_byte(state_t s, int k);
    st_byte = s[STATE_W-1-BYTE_W*k -: BYTE_W];
  endfunction

  function automatic state_t shift_rows(state_t s, logic inv);
    state_t t;
    int     src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? (r + 4 * ((c + 3 * r) & 3)) : (r + 4 * ((c + r) & 3));
        t[STATE_W-1-BYTE_W*(r+4*c) -: BYTE_W] = st_byte(s, src);
      end
    end
    shift_rows = t;
  endfunction

  function automatic state_t mix_columns(state_t s, logic inv);
    state_t            t;
    logic [BYTE_W-1:0] a0, a1, a2, a3;
    logic [BYTE_W-1:0] x2, x4, x8;
    logic [BYTE_W-1:0] y2, y4, y8;
    logic [BYTE_W-1:0] z2, z4, z8;
    logic [BYTE_W-1:0] w2, w4, w8;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a0 = st_byte(s, 4 * c + r);
        a1 = st_byte(s, 4 * c + ((r + 1) & 3));
        a2 = st_byte(s, 4 * c + ((r + 2) & 3));
        a3 = st_byte(s, 4 * c + ((r + 3) & 3));
        x2 = xt(a0); x4 = xt(x2); x8 = xt(x4);
        y2 = xt(a1); y4 = xt(y2); y8 = xt(y4);
        z2 = xt(a2); z4 = xt(z2); z8 = xt(z4);
        w2 = xt(a3); w4 = xt(w2); w8 = xt(w4);
        if (inv) begin
          // 0e.a0 ^ 0b.a1 ^ 0d.a2 ^ 09.a3
          t[STATE_W-1-BYTE_W*(4*c+r) -: BYTE_W] = (x8 ^ x4 ^ x2) ^ (y8 ^ y2 ^ a1)
                                                ^ (z8 ^ z4 ^ a2) ^ (w8 ^ a3);
        end else begin
          t[STATE_W-1-BYTE_W*(4*c+r) -: BYTE_W] = x2 ^ (y2 ^ a1) ^ a2 ^ a3;
        end
      end
    end
    mix_columns = t;
  endfunction

  function automatic state_t transform(kind_t kind, state_t blk, state_t key);
    case (kind)
      KIND_SHIFT:    transform = shift_rows(blk, 1'b0);
      KIND_INVSHIFT: transform = shift_rows(blk, 1'b1);
      KIND_MIX:      transform = mix_columns(blk, 1'b0);
      KIND_INVMIX:   transform = mix_columns(blk, 1'b1);
      KIND_ADDKEY:   transform = blk ^ key;
      default:       transform = '0;
    endcase
  endfunction

endpackage

@@ rtl/aesrt_tbl_ram.sv @@
// Substitution table memory: one write port, two registered read ports.
module aesrt_tbl_ram #(
  parameter int AW = aesrt_pkg::TBL_AW,
  parameter int DW = aesrt_pkg::BYTE_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);
  import aesrt_pkg::*;

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ rtl/aes_round_transform_unit_core.sv @@
// Top level of the AES round transformation unit.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata (index, value, block, key), s_tuser (kind)
//  m_*      out  m_tvalid/m_tready  m_tdata (result_hi, result_lo)
//
// SubBytes and InvSubBytes do 16 lookups per beat through the four read ports of
// two table copies, 4 bytes a cycle while the read-data stage is not stalled; every
// other kind issues as a single beat. Results pass the issue, read-data and output stages.
// rst clears the stage valids and the lookup count; tables are undefined until written.
// A full output register stalls the read-data stage, which holds the memory outputs.
`include "aes_round_transform_unit_core_macros.svh"

module aes_round_transform_unit_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] table_index, [15:8] table_value, [79:16] block_hi,
  // [143:80] block_lo, [207:144] key_hi, [271:208] key_lo
  input  logic [aesrt_pkg::IN_DATA_W-1:0]    s_tdata,
  // [3:0] kind
  input  logic [aesrt_pkg::KIND_W-1:0]       s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [63:0] result_hi, [127:64] result_lo
  output logic [aesrt_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import aesrt_pkg::*;

  // issue stage
  logic              s1_valid;
  kind_t             s1_kind;
  logic [BYTE_W-1:0] s1_idx;
  logic [BYTE_W-1:0] s1_val;
  state_t            s1_blk;
  state_t            s1_key;
  logic [1:0]        s1_cnt;
  logic              s1_is_sub;
  logic              s1_is_wr;
  logic              s1_last;
  logic              adv1;

  // read-data stage
  logic              s2_valid;
  logic              s2_sub;
  logic              s2_last;
  logic [1:0]        s2_chunk;
  state_t            s2_res;
  logic              ready2;
  logic              adv3;

  // output register
  state_t            acc;
  state_t            acc_next;

  // table ports
  logic                 ram_we;
  logic                 ram_re;
  logic [TBL_AW-1:0]    waddr;
  logic [LANE_BITS-1:0] chunk_bytes;
  logic [TBL_AW-1:0]    raddr [LANES];
  logic [BYTE_W-1:0]    rdata [LANES];

  assign s1_is_sub = s1_kind inside {KIND_SUB, KIND_INVSUB};
  assign s1_is_wr  = s1_kind inside {KIND_FWD_WR, KIND_INV_WR};
  assign s1_last   = !s1_is_sub || (s1_cnt == 2'd3);

  assign adv3     = s2_valid && (!m_tvalid || m_tready);
  assign ready2   = !s2_valid || adv3;
  assign adv1     = s1_valid && ready2;
  assign s_tready = !s1_valid || (adv1 && s1_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_cnt   <= 2'd0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (adv1 && s1_is_sub) begin
        s1_cnt <= s1_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_kind <= kind_t'(s_tuser);
      s1_idx  <= s_tdata[7:0];
      s1_val  <= s_tdata[15:8];
      s1_blk  <= {s_tdata[79:16], s_tdata[143:80]};
      s1_key  <= {s_tdata[207:144], s_tdata[271:208]};
    end
  end

  // Writes and lookups issue from the same stage in order, so a lookup always
  // sees every earlier table write.
  assign ram_we      = adv1 && s1_is_wr;
  assign ram_re      = adv1 && s1_is_sub;
  assign waddr       = {s1_kind == KIND_INV_WR, s1_idx};
  assign chunk_bytes = s1_blk[(7'd127 - {s1_cnt, 5'd0}) -: LANE_BITS];

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      raddr[j] = {s1_kind == KIND_INVSUB, chunk_bytes[LANE_BITS-1-BYTE_W*j -: BYTE_W]};
    end
  end

  aesrt_tbl_ram u_ram_a (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr),
    .wdata  (s1_val),
    .re     (ram_re),
    .raddr0 (raddr[0]),
    .raddr1 (raddr[1]),
    .rdata0 (rdata[0]),
    .rdata1 (rdata[1])
  );

  aesrt_tbl_ram u_ram_b (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr),
    .wdata  (s1_val),
    .re     (ram_re),
    .raddr0 (raddr[2]),
    .raddr1 (raddr[3]),
    .rdata0 (rdata[2]),
    .rdata1 (rdata[3])
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= adv1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_sub   <= s1_is_sub;
      s2_last  <= s1_last;
      s2_chunk <= s1_cnt;
      s2_res   <= transform(s1_kind, s1_blk, s1_key);
    end
  end

  always_comb begin
    acc_next = acc;
    if (s2_sub) begin
      acc_next[(7'd127 - {s2_chunk, 5'd0}) -: LANE_BITS] = {rdata[0], rdata[1], rdata[2], rdata[3]};
    end else begin
      acc_next = s2_res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv3 && s2_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {acc[HALF_W-1:0], acc[STATE_W-1:HALF_W]};

  `AESRT_ASSERT(a_cnt_sub_only, (s1_cnt != 2'd0) |-> (s1_valid && s1_is_sub), "lookup count without lookup beat")
  `AESRT_NEVER(a_no_rw_overlap, ram_we && ram_re, "table write and lookup in one cycle")
  `AESRT_ASSERT(a_out_after_last, $rose(m_tvalid) |-> $past(s2_valid && s2_last), "result shown before last chunk")
  `AESRT_ASSERT(a_last_chunk, (s2_valid && s2_sub && s2_last) |-> (s2_chunk == 2'd3), "lookup beat ended early")
  `AESRT_ASSERT(a_intake_lookup, (s1_valid && s1_is_sub && s1_cnt != 2'd3) |-> !s_tready, "intake during lookups")

endmodule

@@ tb/aes_round_transform_unit_core_tb.sv @@
// Testbench for the AES round transformation unit: directed and random beats against a predictor.
`timescale 1ns / 1ps

module aes_round_transform_unit_core_tb;
  import aesrt_pkg::*;

  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_BEATS = 1200;
  localparam int CALM_FIRST   = 400;
  localparam int CALM_LAST    = 600;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = KIND_W'(KIND_ADDKEY + 1);
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = '1;

  localparam logic [LANE_BITS-1:0] FWD_MIX_ROW = 32'h02030101;
  localparam logic [LANE_BITS-1:0] INV_MIX_ROW = 32'h0e0b0d09;

  typedef logic [BYTE_W-1:0] byte_t;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata;
  logic [KIND_W-1:0]       s_tuser;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;

  byte_t  fwd_tbl_mirror [256];
  byte_t  inv_tbl_mirror [256];
  bit     fwd_loaded [256];
  bit     inv_loaded [256];
  byte_t  fwd_loaded_idx [$];
  byte_t  inv_loaded_idx [$];
  state_t expected_states [$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  bit     calm;

  aes_round_transform_unit_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic byte_t gf_times(byte_t a, byte_t b);
    byte_t p;
    p = '0;
    for (int n = 0; n < BYTE_W; n++) begin
      if (b[0]) p ^= a;
      a = a[BYTE_W-1] ? ({a[BYTE_W-2:0], 1'b0} ^ AES_POLY) : {a[BYTE_W-2:0], 1'b0};
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic state_t substitute_state(state_t s, bit inv);
    state_t t;
    byte_t  v;
    for (int k = 0; k < 16; k++) begin
      v = s[STATE_W-1-BYTE_W*k -: BYTE_W];
      t[STATE_W-1-BYTE_W*k -: BYTE_W] = inv ? inv_tbl_mirror[v] : fwd_tbl_mirror[v];
    end
    return t;
  endfunction

  // dir 1 rotates rows left, dir 3 rotates them right
  function automatic state_t rotate_rows(state_t s, int dir);
    state_t t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[STATE_W-1-BYTE_W*(r+4*c) -: BYTE_W] =
          s[STATE_W-1-BYTE_W*(r+4*((c+dir*r)&3)) -: BYTE_W];
    return t;
  endfunction

  function automatic state_t mix_state(state_t s, logic [LANE_BITS-1:0] row);
    state_t t;
    byte_t  acc;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = '0;
        for (int i = 0; i < 4; i++)
          acc ^= gf_times(row[LANE_BITS-1-BYTE_W*((i-r+4)&3) -: BYTE_W],
                          s[STATE_W-1-BYTE_W*(4*c+i) -: BYTE_W]);
        t[STATE_W-1-BYTE_W*(4*c+r) -: BYTE_W] = acc;
      end
    return t;
  endfunction

  function automatic state_t apply_round_op(logic [KIND_W-1:0] kind, byte_t idx, byte_t val,
                                            state_t blk, state_t key);
    state_t r;
    r = '0;
    case (kind)
      KIND_FWD_WR: begin
        fwd_tbl_mirror[idx] = val;
        if (!fwd_loaded[idx]) begin
          fwd_loaded[idx] = 1'b1;
          fwd_loaded_idx.push_back(idx);
        end
      end
      KIND_INV_WR: begin
        inv_tbl_mirror[idx] = val;
        if (!inv_loaded[idx]) begin
          inv_loaded[idx] = 1'b1;
          inv_loaded_idx.push_back(idx);
        end
      end
      KIND_SUB:      r = substitute_state(blk, 1'b0);
      KIND_INVSUB:   r = substitute_state(blk, 1'b1);
      KIND_SHIFT:    r = rotate_rows(blk, 1);
      KIND_INVSHIFT: r = rotate_rows(blk, 3);
      KIND_MIX:      r = mix_state(blk, FWD_MIX_ROW);
      KIND_INVMIX:   r = mix_state(blk, INV_MIX_ROW);
      KIND_ADDKEY:   r = blk ^ key;
      default: ;
    endcase
    return r;
  endfunction

  function automatic state_t rand_state();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // state whose every byte addresses an entry already loaded
  function automatic state_t loaded_state(bit inv);
    state_t s;
    for (int k = 0; k < 16; k++)
      s[STATE_W-1-BYTE_W*k -: BYTE_W] = inv ?
        inv_loaded_idx[$urandom_range(inv_loaded_idx.size() - 1)] :
        fwd_loaded_idx[$urandom_range(fwd_loaded_idx.size() - 1)];
    return s;
  endfunction

  task automatic send_beat(logic [KIND_W-1:0] kind, byte_t idx, byte_t val,
                           state_t blk, state_t key);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {key[HALF_W-1:0], key[STATE_W-1:HALF_W],
                 blk[HALF_W-1:0], blk[STATE_W-1:HALF_W], val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_states.push_back(apply_round_op(kind, idx, val, blk, key));
  endtask

  task automatic test_table_loads();
    send_beat(KIND_FWD_WR, 8'h00, 8'h63, rand_state(), rand_state());
    send_beat(KIND_FWD_WR, 8'hff, 8'h16, rand_state(), rand_state());
    send_beat(KIND_FWD_WR, 8'h53, 8'hed, '1, '1);
    send_beat(KIND_FWD_WR, 8'ha5, 8'h00, '0, '0);
    send_beat(KIND_INV_WR, 8'h00, 8'h52, rand_state(), rand_state());
    send_beat(KIND_INV_WR, 8'hff, 8'h7d, '1, '1);
    send_beat(KIND_INV_WR, 8'h63, 8'hff, '0, '0);
    send_beat(KIND_INV_WR, 8'h5a, 8'ha5, rand_state(), rand_state());
  endtask

  task automatic test_substitution();
    send_beat(KIND_SUB, '0, '0, '0, rand_state());
    send_beat(KIND_SUB, '1, '1, 128'h0053a5ff_ff00a553_5353a5a5_ffff0000, '1);
    send_beat(KIND_INVSUB, '0, '0, 128'h00ff635a_5a63ff00_ffffffff_00000000, '0);
    // read of an entry in the beat right after its write
    send_beat(KIND_FWD_WR, 8'h77, 8'h88, rand_state(), rand_state());
    send_beat(KIND_SUB, '0, '0, {16{8'h77}}, rand_state());
  endtask

  task automatic test_row_shifts();
    send_beat(KIND_SHIFT, '0, '0, 128'h00010203_04050607_08090a0b_0c0d0e0f, '0);
    send_beat(KIND_INVSHIFT, '1, '1, 128'h00010203_04050607_08090a0b_0c0d0e0f, '1);
    send_beat(KIND_SHIFT, '0, '0, '1, rand_state());
  endtask

  task automatic test_column_mix();
    send_beat(KIND_MIX, '0, '0, 128'hdb135345_f20a225c_01010101_c6c6c6c6, '0);
    send_beat(KIND_MIX, '0, '0, '1, '1);
    send_beat(KIND_INVMIX, '0, '0, 128'h8e4da1bc_9fdc589d_01010101_c6c6c6c6, '0);
    send_beat(KIND_INVMIX, '1, '1, '1, '0);
  endtask

  task automatic test_round_key();
    send_beat(KIND_ADDKEY, '0, '0, '1, '0);
    send_beat(KIND_ADDKEY, '1, '1, rand_state(), '1);
  endtask

  task automatic test_spare_kinds();
    send_beat(KIND_SPARE_FIRST, '1, '1, rand_state(), rand_state());
    send_beat(KIND_SPARE_LAST, '0, '0, '1, '1);
  endtask

  task automatic test_random_mix();
    logic [KIND_W-1:0] kind;
    int                roll;
    state_t            blk;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      roll = $urandom_range(99);
      if (roll < 8)       kind = KIND_FWD_WR;
      else if (roll < 16) kind = KIND_INV_WR;
      else if (roll < 20) kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      else                kind = KIND_W'($urandom_range(KIND_SUB, KIND_ADDKEY));
      if (kind == KIND_SUB && fwd_loaded_idx.size() == 0) kind = KIND_SHIFT;
      if (kind == KIND_INVSUB && inv_loaded_idx.size() == 0) kind = KIND_INVSHIFT;
      if (kind == KIND_SUB)         blk = loaded_state(1'b0);
      else if (kind == KIND_INVSUB) blk = loaded_state(1'b1);
      else                          blk = rand_state();
      send_beat(kind, BYTE_W'($urandom), BYTE_W'($urandom), blk, rand_state());
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    state_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_states.size() == 0) begin
        $error("result beat with none expected: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_states.pop_front();
        if (m_tdata[HALF_W-1:0] !== want[STATE_W-1:HALF_W]) begin
          $error("result_hi: expected %h, actual %h", want[STATE_W-1:HALF_W],
                 m_tdata[HALF_W-1:0]);
          mismatch_count++;
        end
        if (m_tdata[OUT_DATA_W-1:HALF_W] !== want[HALF_W-1:0]) begin
          $error("result_lo: expected %h, actual %h", want[HALF_W-1:0],
                 m_tdata[OUT_DATA_W-1:HALF_W]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    calm           = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_table_loads();
    test_substitution();
    test_row_shifts();
    test_column_mix();
    test_round_key();
    test_spare_kinds();
    test_random_mix();
    s_tvalid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ aes_round_transform_unit_core.f @@
+incdir+rtl
rtl/aesrt_pkg.sv
rtl/aesrt_tbl_ram.sv
rtl/aes_round_transform_unit_core.sv
tb/aes_round_transform_unit_core_tb.sv
